[rtl/sdac_pkg.sv]
// Shared types and constants for the sliding delayed autocorrelator.
`timescale 1ns / 1ps
package sdac_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int CORR_W    = 41;
  localparam int WIN_W     = 9;
  localparam int LAG_W     = 11;
  localparam int CFG_W     = 11;
  localparam int REG_IDX_W = 2;
  localparam int FRAC      = 30;

  localparam logic [REG_IDX_W-1:0] REG_WINDOW_LEN = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_LAG        = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_NORMALIZE  = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_CONJ       = 2'd3;

  typedef enum logic [1:0] {
    F_IDLE,
    F_READ2,
    F_ADD,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    SRC_NEW,
    SRC_MEM,
    SRC_ZERO
  } src_t;

  typedef enum logic [2:0] {
    N_IDLE,
    N_MULP,
    N_MULS,
    N_DIV,
    N_SQRT,
    N_OUT
  } norm_state_t;

endpackage

[rtl/sdac_front.sv]
// Front end: sample history memory and running window sums.
`timescale 1ns / 1ps
module sdac_front #(
  parameter int MAX_WINDOW = 256,
  parameter int MAX_LAG    = 1024,
  parameter int SUM_W      = 41,
  parameter int EN_W       = 40
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                clear,
  input  logic                                conj,
  input  logic [sdac_pkg::WIN_W-1:0]          window_len,
  input  logic [sdac_pkg::LAG_W-1:0]          lag,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [sdac_pkg::SAMPLE_W-1:0] sample_re,
  input  logic signed [sdac_pkg::SAMPLE_W-1:0] sample_im,
  input  logic                                push_ready,
  output logic                                push,
  output logic [2*sdac_pkg::SAMPLE_W-1:0]     passed,
  output logic signed [SUM_W-1:0]             sum_re,
  output logic signed [SUM_W-1:0]             sum_im,
  output logic [EN_W-1:0]                     en_early,
  output logic [EN_W-1:0]                     en_late
);
  import sdac_pkg::*;

  localparam int HIST   = MAX_WINDOW + MAX_LAG;
  localparam int PTR_W  = $clog2(HIST);
  localparam int FILL_W = $clog2(HIST + 1);
  localparam int CW     = ((PTR_W > LAG_W) ? PTR_W : LAG_W) + 1;

  front_state_t state, state_next;

  logic [2*SAMPLE_W-1:0] hist [HIST];
  logic [2*SAMPLE_W-1:0] rd_a, rd_b, rd_c, new_s;
  logic [PTR_W-1:0]      wr_pos;
  logic [FILL_W-1:0]     fill;
  src_t                  src_a, src_b, src_c;

  logic [CW-1:0]    win_wide, lag_wide, w_c, lag_c;
  logic [PTR_W-1:0] m_lag, m_wm1, m_sum;
  logic [PTR_W-1:0] addr_a, addr_b, addr_c;
  logic             accept;

  logic [2*SAMPLE_W-1:0]       op_e, op_l;
  logic signed [SAMPLE_W-1:0]  a, b, c, d;
  logic signed [31:0]          ac, bd, bc, ad, aa, bb, cc, dd;
  logic signed [32:0]          pr_c, pi_c, p_cr, p_ci;
  logic [31:0]                 ee_c, el_c, p_ee, p_el;

  function automatic logic [PTR_W-1:0] back_addr(input logic [PTR_W-1:0] wr,
                                                input logic [PTR_W-1:0] m);
    logic [PTR_W:0] diff;
    diff = {1'b0, wr} - {1'b0, m};
    if (diff[PTR_W]) diff = diff + (PTR_W + 1)'(HIST);
    return diff[PTR_W-1:0];
  endfunction

  function automatic src_t src_of(input logic [PTR_W-1:0] m,
                                  input logic [FILL_W-1:0] f);
    if (m == '0) return SRC_NEW;
    if (FILL_W'(m) <= f) return SRC_MEM;
    return SRC_ZERO;
  endfunction

  function automatic logic [2*SAMPLE_W-1:0] pick(input logic [2*SAMPLE_W-1:0] mem_d,
                                                 input src_t s,
                                                 input logic [2*SAMPLE_W-1:0] nw);
    logic [2*SAMPLE_W-1:0] r;
    unique case (s)
      SRC_NEW: r = nw;
      SRC_MEM: r = mem_d;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Clamp the window and lag registers into the supported range.
  always_comb begin
    win_wide = CW'(window_len);
    lag_wide = CW'(lag);
    if (win_wide == '0) w_c = CW'(1);
    else if (win_wide > CW'(MAX_WINDOW)) w_c = CW'(MAX_WINDOW);
    else w_c = win_wide;
    if (lag_wide > CW'(MAX_LAG)) lag_c = CW'(MAX_LAG);
    else lag_c = lag_wide;
    m_lag = PTR_W'(lag_c);
    m_wm1 = PTR_W'(w_c - CW'(1));
    m_sum = PTR_W'(lag_c + w_c - CW'(1));
    addr_a = back_addr(wr_pos, m_lag);
    addr_b = back_addr(wr_pos, m_wm1);
    addr_c = back_addr(wr_pos, m_sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    push       = 1'b0;
    accept     = 1'b0;
    unique case (state)
      F_IDLE: begin
        in_stall = 1'b0;
        accept   = in_valid;
        if (in_valid) state_next = F_READ2;
      end
      F_READ2: state_next = F_ADD;
      F_ADD:   state_next = F_PUSH;
      F_PUSH: begin
        push = push_ready;
        if (push_ready) state_next = F_IDLE;
      end
      default: state_next = F_IDLE;
    endcase
  end

  // History memory: one write and two reads at accept, one read after.
  always_ff @(posedge clk) begin
    if (accept) begin
      hist[wr_pos] <= {sample_im, sample_re};
      rd_a         <= hist[addr_a];
      rd_b         <= hist[addr_b];
    end
    if (state == F_READ2) begin
      rd_c <= hist[addr_c];
    end
  end

  // Pair products: the entering pair in READ2, the leaving pair in ADD.
  always_comb begin
    if (state == F_READ2) begin
      op_e = pick(rd_a, src_a, new_s);
      op_l = new_s;
    end else begin
      op_e = pick(rd_c, src_c, new_s);
      op_l = pick(rd_b, src_b, new_s);
    end
    a  = op_e[SAMPLE_W-1:0];
    b  = op_e[2*SAMPLE_W-1:SAMPLE_W];
    c  = op_l[SAMPLE_W-1:0];
    d  = op_l[2*SAMPLE_W-1:SAMPLE_W];
    ac = a * c;
    bd = b * d;
    bc = b * c;
    ad = a * d;
    aa = a * a;
    bb = b * b;
    cc = c * c;
    dd = d * d;
    pr_c = {ac[31], ac} + {bd[31], bd};
    if (conj) pi_c = {bc[31], bc} - {ad[31], ad};
    else pi_c = {ad[31], ad} - {bc[31], bc};
    ee_c = $unsigned(aa) + $unsigned(bb);
    el_c = $unsigned(cc) + $unsigned(dd);
  end

  assign passed = pick(rd_c, src_c, new_s);

  always_ff @(posedge clk) begin
    if (state == F_READ2 || state == F_ADD) begin
      p_cr <= pr_c;
      p_ci <= pi_c;
      p_ee <= ee_c;
      p_el <= el_c;
    end
    if (accept) begin
      new_s <= {sample_im, sample_re};
      src_a <= src_of(m_lag, fill);
      src_b <= src_of(m_wm1, fill);
      src_c <= src_of(m_sum, fill);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      wr_pos   <= '0;
      fill     <= '0;
      sum_re   <= '0;
      sum_im   <= '0;
      en_early <= '0;
      en_late  <= '0;
    end else if (state == F_ADD) begin
      sum_re   <= sum_re + SUM_W'(p_cr);
      sum_im   <= sum_im + SUM_W'(p_ci);
      en_early <= en_early + EN_W'(p_ee);
      en_late  <= en_late + EN_W'(p_el);
    end else if (push) begin
      sum_re   <= sum_re - SUM_W'(p_cr);
      sum_im   <= sum_im - SUM_W'(p_ci);
      en_early <= en_early - EN_W'(p_ee);
      en_late  <= en_late - EN_W'(p_el);
      wr_pos   <= (wr_pos == PTR_W'(HIST - 1)) ? '0 : wr_pos + PTR_W'(1);
      if (fill != FILL_W'(HIST)) fill <= fill + FILL_W'(1);
    end
  end

endmodule

[rtl/sdac_queue.sv]
// Two-entry request queue between the front end and the normalizer.
`timescale 1ns / 1ps
module sdac_queue #(
  parameter int WIDTH = 194
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);
  import sdac_pkg::*;

  logic [WIDTH-1:0] slots [2];
  logic             wr_ptr, rd_ptr;
  logic [1:0]       count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

endmodule

[rtl/sdac_norm.sv]
// Back end: optional normalization by serial multiply, divide and square root.
`timescale 1ns / 1ps
module sdac_norm #(
  parameter int SUM_W = 41,
  parameter int EN_W  = 40
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 normalize,
  input  logic                                 q_empty,
  output logic                                 q_pop,
  input  logic [2*sdac_pkg::SAMPLE_W-1:0]      q_passed,
  input  logic signed [SUM_W-1:0]              q_sum_re,
  input  logic signed [SUM_W-1:0]              q_sum_im,
  input  logic [EN_W-1:0]                      q_en_early,
  input  logic [EN_W-1:0]                      q_en_late,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [sdac_pkg::SAMPLE_W-1:0] passed_re,
  output logic signed [sdac_pkg::SAMPLE_W-1:0] passed_im,
  output logic signed [sdac_pkg::CORR_W-1:0]   corr_re,
  output logic signed [sdac_pkg::CORR_W-1:0]   corr_im,
  output logic                                 energy_zero
);
  import sdac_pkg::*;

  localparam int OP_W  = (SUM_W > EN_W) ? SUM_W : EN_W;
  localparam int PW    = 2 * OP_W;
  localparam int QB    = 2 * FRAC + 1;
  localparam int RAD_W = 2 * (FRAC + 1);
  localparam int RT_W  = FRAC + 1;
  localparam int SQ_W  = FRAC + 5;
  localparam int CNT_W = $clog2(((OP_W > QB) ? OP_W : QB) + 1);

  norm_state_t state, state_next;

  logic [2*SAMPLE_W-1:0]     w_passed;
  logic [SUM_W-1:0]          mag_re, mag_im;
  logic                      neg_re, neg_im, comp;
  logic [PW-1:0]             mc, acc, pdiv, acc_sum;
  logic [OP_W-1:0]           mp;
  logic [PW:0]               rem, rem_sub, rem_keep;
  logic                      ge;
  logic [QB-1:0]             q, q_next;
  logic [RAD_W-1:0]          rad;
  logic [RT_W-1:0]           root, root_next;
  logic [SQ_W-1:0]           srem, srem_sh, srem_next, trial;
  logic [CNT_W-1:0]          cnt;
  logic signed [CORR_W-1:0]  res_re, res_im, root_signed;
  logic                      res_ez, load_out, head_zero;

  function automatic logic [SUM_W-1:0] mag_of(input logic signed [SUM_W-1:0] s);
    return s[SUM_W-1] ? $unsigned(-s) : $unsigned(s);
  endfunction

  assign head_zero = (q_en_early == '0) || (q_en_late == '0);
  assign load_out  = (state == N_OUT) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    unique case (state)
      N_IDLE: begin
        q_pop = !q_empty;
        if (!q_empty) begin
          if (!normalize || head_zero) state_next = N_OUT;
          else state_next = N_MULP;
        end
      end
      N_MULP: if (cnt == '0) state_next = N_MULS;
      N_MULS: if (cnt == '0) state_next = N_DIV;
      N_DIV:  if (cnt == '0) state_next = N_SQRT;
      N_SQRT: if (cnt == '0) state_next = comp ? N_OUT : N_MULS;
      N_OUT:  if (load_out) state_next = N_IDLE;
      default: state_next = N_IDLE;
    endcase
  end

  // One step of each serial unit.
  always_comb begin
    acc_sum   = acc + (mp[0] ? mc : '0);
    rem_sub   = rem - {1'b0, pdiv};
    ge        = (rem >= {1'b0, pdiv});
    rem_keep  = ge ? rem_sub : rem;
    q_next    = {q[QB-2:0], ge};
    srem_sh   = {srem[SQ_W-3:0], rad[RAD_W-1:RAD_W-2]};
    trial     = SQ_W'({root, 2'b01});
    if (srem_sh >= trial) begin
      srem_next = srem_sh - trial;
      root_next = {root[RT_W-2:0], 1'b1};
    end else begin
      srem_next = srem_sh;
      root_next = {root[RT_W-2:0], 1'b0};
    end
    root_signed = (comp ? neg_im : neg_re) ? -CORR_W'(root_next) : CORR_W'(root_next);
  end

  always_ff @(posedge clk) begin
    unique case (state)
      N_IDLE: begin
        w_passed <= q_passed;
        mag_re   <= mag_of(q_sum_re);
        mag_im   <= mag_of(q_sum_im);
        neg_re   <= q_sum_re[SUM_W-1];
        neg_im   <= q_sum_im[SUM_W-1];
        comp     <= 1'b0;
        mc       <= PW'(q_en_early);
        mp       <= OP_W'(q_en_late);
        acc      <= '0;
        cnt      <= CNT_W'(OP_W - 1);
        if (!normalize) begin
          res_re <= CORR_W'(q_sum_re);
          res_im <= CORR_W'(q_sum_im);
          res_ez <= 1'b0;
        end else begin
          res_re <= '0;
          res_im <= '0;
          res_ez <= head_zero;
        end
      end
      N_MULP, N_MULS: begin
        acc <= acc_sum;
        mc  <= mc << 1;
        mp  <= mp >> 1;
        cnt <= cnt - CNT_W'(1);
        if (cnt == '0) begin
          if (state == N_MULP) begin
            pdiv <= acc_sum;
            mc   <= PW'(mag_re);
            mp   <= OP_W'(mag_re);
            acc  <= '0;
            cnt  <= CNT_W'(OP_W - 1);
          end else begin
            rem <= (PW + 1)'(acc_sum);
            q   <= '0;
            cnt <= CNT_W'(QB - 1);
          end
        end
      end
      N_DIV: begin
        rem <= rem_keep << 1;
        q   <= q_next;
        cnt <= cnt - CNT_W'(1);
        if (cnt == '0) begin
          rad  <= RAD_W'(q_next);
          srem <= '0;
          root <= '0;
          cnt  <= CNT_W'(RT_W - 1);
        end
      end
      N_SQRT: begin
        rad  <= rad << 2;
        srem <= srem_next;
        root <= root_next;
        cnt  <= cnt - CNT_W'(1);
        if (cnt == '0) begin
          if (comp) begin
            res_im <= root_signed;
          end else begin
            res_re <= root_signed;
            comp   <= 1'b1;
            mc     <= PW'(mag_im);
            mp     <= OP_W'(mag_im);
            acc    <= '0;
            cnt    <= CNT_W'(OP_W - 1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      passed_re   <= w_passed[SAMPLE_W-1:0];
      passed_im   <= w_passed[2*SAMPLE_W-1:SAMPLE_W];
      corr_re     <= res_re;
      corr_im     <= res_im;
      energy_zero <= res_ez;
    end
  end

endmodule

[rtl/sliding_delayed_autocorrelator_unit.sv]
// Top level of the sliding delayed autocorrelator.
//
//   channel  | handshake              | payload
//   ---------+------------------------+----------------------------------------
//   in       | in_valid / in_stall    | sample_re, sample_im
//   out      | out_valid / out_stall  | passed_re, passed_im, corr_re, corr_im,
//            |                        | energy_zero
//   config   | cfg_write              | cfg_index, cfg_data
//
// The front end takes one request at a time: IDLE writes the sample and reads two
// history taps, READ2 reads the third tap, ADD adds the entering pair and PUSH
// retires the leaving pair into the queue, waiting while the queue is full.
// Without normalization the back end moves a popped request straight to its output
// register, as it does when an energy is zero. With normalization the serial
// multiplier, divider and square root run for the real part, then the imaginary.
// Synchronous reset returns both halves to idle and empties the queue and sums;
// a config write also clears the history fill count and the running sums.
// A stalled output holds its result; the queue lets the front end keep working.
`timescale 1ns / 1ps
module sliding_delayed_autocorrelator_unit #(
  parameter int MAX_WINDOW = 256,
  parameter int MAX_LAG    = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [sdac_pkg::SAMPLE_W-1:0] sample_re,
  input  logic signed [sdac_pkg::SAMPLE_W-1:0] sample_im,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [sdac_pkg::SAMPLE_W-1:0] passed_re,
  output logic signed [sdac_pkg::SAMPLE_W-1:0] passed_im,
  output logic signed [sdac_pkg::CORR_W-1:0]   corr_re,
  output logic signed [sdac_pkg::CORR_W-1:0]   corr_im,
  output logic                                 energy_zero,
  input  logic                                 cfg_write,
  input  logic [sdac_pkg::REG_IDX_W-1:0]       cfg_index,
  input  logic [sdac_pkg::CFG_W-1:0]           cfg_data
);
  import sdac_pkg::*;

  // Sum widths follow from the largest window: each pair contributes at most
  // 2^31 in magnitude.
  localparam int SUM_W   = 33 + $clog2(MAX_WINDOW);
  localparam int EN_W    = 32 + $clog2(MAX_WINDOW);
  localparam int ENTRY_W = 2 * SAMPLE_W + 2 * SUM_W + 2 * EN_W;

  logic [WIN_W-1:0] window_len;
  logic [LAG_W-1:0] lag;
  logic             normalize, conj, clear;

  logic                    push, q_full, q_empty, q_pop;
  logic [2*SAMPLE_W-1:0]   f_passed, h_passed;
  logic signed [SUM_W-1:0] f_sum_re, f_sum_im, h_sum_re, h_sum_im;
  logic [EN_W-1:0]         f_en_early, f_en_late, h_en_early, h_en_late;
  logic [ENTRY_W-1:0]      q_in, q_out;

  // Configuration registers. Every write restarts the stream from an empty
  // history so the running sums always match the window that is set.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= WIN_W'(16);
      lag        <= LAG_W'(64);
      normalize  <= 1'b0;
      conj       <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_WINDOW_LEN: window_len <= cfg_data[WIN_W-1:0];
        REG_LAG:        lag        <= cfg_data[LAG_W-1:0];
        REG_NORMALIZE:  normalize  <= cfg_data[0];
        REG_CONJ:       conj       <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign clear = cfg_write;

  sdac_front #(
    .MAX_WINDOW (MAX_WINDOW),
    .MAX_LAG    (MAX_LAG),
    .SUM_W      (SUM_W),
    .EN_W       (EN_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .clear      (clear),
    .conj       (conj),
    .window_len (window_len),
    .lag        (lag),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .sample_re  (sample_re),
    .sample_im  (sample_im),
    .push_ready (!q_full),
    .push       (push),
    .passed     (f_passed),
    .sum_re     (f_sum_re),
    .sum_im     (f_sum_im),
    .en_early   (f_en_early),
    .en_late    (f_en_late)
  );

  assign q_in = {f_passed, f_sum_re, f_sum_im, f_en_early, f_en_late};
  assign {h_passed, h_sum_re, h_sum_im, h_en_early, h_en_late} = q_out;

  sdac_queue #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  sdac_norm #(
    .SUM_W (SUM_W),
    .EN_W  (EN_W)
  ) u_norm (
    .clk         (clk),
    .rst         (rst),
    .normalize   (normalize),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .q_passed    (h_passed),
    .q_sum_re    (h_sum_re),
    .q_sum_im    (h_sum_im),
    .q_en_early  (h_en_early),
    .q_en_late   (h_en_late),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .passed_re   (passed_re),
    .passed_im   (passed_im),
    .corr_re     (corr_re),
    .corr_im     (corr_im),
    .energy_zero (energy_zero)
  );

endmodule

[rtl/sdac_port_checker.sv]
// Port-level checks for the sliding delayed autocorrelator, bound to the top level.
`timescale 1ns / 1ps
module sdac_port_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic signed [sdac_pkg::SAMPLE_W-1:0] passed_re,
  input logic signed [sdac_pkg::SAMPLE_W-1:0] passed_im,
  input logic signed [sdac_pkg::CORR_W-1:0]   corr_re,
  input logic signed [sdac_pkg::CORR_W-1:0]   corr_im,
  input logic                                 energy_zero
);
  import sdac_pkg::*;

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(corr_re) && $stable(corr_im)
      && $stable(passed_re) && $stable(passed_im) && $stable(energy_zero))
    else $error("stalled result changed");

  // A forced-zero result carries a zero correlation.
  a_zero_energy: assert property (@(posedge clk) disable iff (rst)
    out_valid && energy_zero |-> corr_re == '0 && corr_im == '0)
    else $error("energy_zero with nonzero correlation");

  // Reset leaves the output empty and the input open.
  a_reset_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present after reset");

  a_reset_in: assert property (@(posedge clk) rst |=> !in_stall)
    else $error("input stalled after reset");

  // An accepted request keeps the input closed in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input open right after a request");

endmodule

bind sliding_delayed_autocorrelator_unit sdac_port_checker u_port_checker (.*);

[bench/sliding_delayed_autocorrelator_unit_tb.sv]
// Self-checking testbench for the sliding delayed autocorrelator unit.
`timescale 1ns / 1ps
module sliding_delayed_autocorrelator_unit_tb;
  import sdac_pkg::*;

  localparam int HIST_LEN  = 1280;
  localparam int WIN_MAX   = 256;
  localparam int LAG_MAX   = 1024;
  localparam int CYCLE_CAP = 3000000;

  // One expected result as the block should deliver it.
  typedef struct {
    logic signed [SAMPLE_W-1:0] passed_re;
    logic signed [SAMPLE_W-1:0] passed_im;
    logic signed [CORR_W-1:0]   corr_re;
    logic signed [CORR_W-1:0]   corr_im;
    logic                       energy_zero;
  } corr_result_t;

  // Scoreboard: it mirrors the delay line, the running sums and the registers,
  // predicts one result per accepted request and checks results in order.
  class autocorr_scoreboard;
    logic [31:0]        history [HIST_LEN];
    int                 wr_idx;
    longint             xsum_re, xsum_im, en_early, en_late;
    logic [WIN_W-1:0]   win_reg;
    logic [LAG_W-1:0]   lag_reg;
    bit                 norm_reg, conj_reg;
    corr_result_t       awaiting [$];

    function void clear_stream();
      foreach (history[i]) history[i] = '0;
      wr_idx = 0;
      xsum_re = 0;
      xsum_im = 0;
      en_early = 0;
      en_late = 0;
    endfunction

    function void reset_state();
      win_reg = 16;
      lag_reg = 64;
      norm_reg = 0;
      conj_reg = 0;
      clear_stream();
      awaiting.delete();
    endfunction

    function void write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_WINDOW_LEN: win_reg = data[WIN_W-1:0];
        REG_LAG:        lag_reg = data[LAG_W-1:0];
        REG_NORMALIZE:  norm_reg = data[0];
        default:        conj_reg = data[0];
      endcase
      clear_stream();
    endfunction

    function logic [31:0] tap(int m);
      return history[(wr_idx + HIST_LEN - (m % HIST_LEN)) % HIST_LEN];
    endfunction

    // Adds (dir = 1) or removes (dir = -1) one early/late pair from the sums.
    function void move_pair(logic [31:0] early, logic [31:0] late, longint dir);
      longint a, b, c, d, pi;
      a = longint'($signed(early[15:0]));
      b = longint'($signed(early[31:16]));
      c = longint'($signed(late[15:0]));
      d = longint'($signed(late[31:16]));
      pi = conj_reg ? (b * c - a * d) : (a * d - b * c);
      xsum_re += dir * (a * c + b * d);
      xsum_im += dir * pi;
      en_early += dir * (a * a + b * b);
      en_late += dir * (c * c + d * d);
    endfunction

    // Largest q with q*q*e1*e2 <= s*s*2^60, carrying the sign of s.
    function longint scale_q30(longint s, longint e1, longint e2);
      bit [159:0] rhs, prod, lhs;
      longint mag, lo, hi, mid;
      mag = (s < 0) ? -s : s;
      rhs = (160'(mag) * 160'(mag)) << 60;
      prod = 160'(e1) * 160'(e2);
      lo = 0;
      hi = longint'(1) << 30;
      while (lo < hi) begin
        mid = lo + (hi - lo + 1) / 2;
        lhs = 160'(mid) * 160'(mid) * prod;
        if (lhs <= rhs) lo = mid;
        else hi = mid - 1;
      end
      return (s < 0) ? -lo : lo;
    endfunction

    function void note_sample(logic [15:0] re, logic [15:0] im);
      int w, lg;
      logic [31:0] leaving;
      longint r_re, r_im;
      corr_result_t exp_res;
      w = (win_reg < 1) ? 1 : ((win_reg > WIN_MAX) ? WIN_MAX : int'(win_reg));
      lg = (lag_reg > LAG_MAX) ? LAG_MAX : int'(lag_reg);
      history[wr_idx] = {im, re};
      move_pair(tap(lg), tap(0), 1);
      r_re = xsum_re;
      r_im = xsum_im;
      exp_res.energy_zero = 1'b0;
      if (norm_reg) begin
        if (en_early <= 0 || en_late <= 0) begin
          r_re = 0;
          r_im = 0;
          exp_res.energy_zero = 1'b1;
        end else begin
          r_re = scale_q30(r_re, en_early, en_late);
          r_im = scale_q30(r_im, en_early, en_late);
        end
      end
      leaving = tap(lg + w - 1);
      move_pair(leaving, tap(w - 1), -1);
      wr_idx = (wr_idx + 1) % HIST_LEN;
      exp_res.passed_re = leaving[15:0];
      exp_res.passed_im = leaving[31:16];
      exp_res.corr_re = r_re[CORR_W-1:0];
      exp_res.corr_im = r_im[CORR_W-1:0];
      awaiting.push_back(exp_res);
    endfunction

    // Compares one delivered result with the oldest prediction; every
    // disagreement becomes one line of text in faults.
    function void check_result(corr_result_t got, ref string faults [$]);
      corr_result_t exp_res;
      if (awaiting.size() == 0) begin
        faults.push_back("result arrived with no request outstanding");
        return;
      end
      exp_res = awaiting.pop_front();
      if (got.passed_re !== exp_res.passed_re)
        faults.push_back($sformatf("passed_re got %0d want %0d",
                                   got.passed_re, exp_res.passed_re));
      if (got.passed_im !== exp_res.passed_im)
        faults.push_back($sformatf("passed_im got %0d want %0d",
                                   got.passed_im, exp_res.passed_im));
      if (got.corr_re !== exp_res.corr_re)
        faults.push_back($sformatf("corr_re got %0d want %0d",
                                   got.corr_re, exp_res.corr_re));
      if (got.corr_im !== exp_res.corr_im)
        faults.push_back($sformatf("corr_im got %0d want %0d",
                                   got.corr_im, exp_res.corr_im));
      if (got.energy_zero !== exp_res.energy_zero)
        faults.push_back($sformatf("energy_zero got %0b want %0b",
                                   got.energy_zero, exp_res.energy_zero));
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] sample_re = '0;
  logic signed [SAMPLE_W-1:0] sample_im = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] passed_re, passed_im;
  logic signed [CORR_W-1:0]   corr_re, corr_im;
  logic                       energy_zero;
  logic                       cfg_write = 1'b0;
  logic [REG_IDX_W-1:0]       cfg_index = '0;
  logic [CFG_W-1:0]           cfg_data = '0;

  autocorr_scoreboard sb;
  int     mismatches = 0;
  int     requests_sent = 0;
  int     send_idle_pct = 33;
  int     recv_stall_pct = 47;
  int     hold_off_left = 0;
  longint cycle_count = 0;

  sliding_delayed_autocorrelator_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .sample_re(sample_re), .sample_im(sample_im),
    .out_valid(out_valid), .out_stall(out_stall),
    .passed_re(passed_re), .passed_im(passed_im),
    .corr_re(corr_re), .corr_im(corr_im), .energy_zero(energy_zero),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  task automatic report(string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // The watchdog bounds the run in case the block stops delivering results.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // The receiver stalls at random, and once it holds off for a long stretch so
  // that the internal queue fills and the block has to stall the sender.
  always @(posedge clk) begin
    if (requests_sent == 200 && hold_off_left == 0 && !rst)
      hold_off_left = 3000;
    if (hold_off_left > 0) begin
      hold_off_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Results are sampled at the clock edge, so the values seen are the ones
  // that were stable during the cycle before it.
  always @(posedge clk) begin
    corr_result_t got;
    string faults [$];
    faults.delete();
    if (!rst && out_valid && !out_stall) begin
      got.passed_re = passed_re;
      got.passed_im = passed_im;
      got.corr_re = corr_re;
      got.corr_im = corr_im;
      got.energy_zero = energy_zero;
      sb.check_result(got, faults);
      foreach (faults[i]) report(faults[i]);
    end
  end

  // Sends one request. A random gap may come first; valid then stays high
  // until the block takes the request, and the payload is held meanwhile.
  task automatic send_sample(logic [15:0] re, logic [15:0] im);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample_re <= re;
    sample_im <= im;
    do @(posedge clk); while (in_stall);
    sb.note_sample(re, im);
    requests_sent++;
    // The idling mix shifts as the run goes on: receiver-heavy stalls first,
    // then sender-heavy gaps, then full rate on both sides.
    if (requests_sent == 620) begin
      send_idle_pct = 47;
      recv_stall_pct = 33;
    end else if (requests_sent == 1240) begin
      send_idle_pct = 0;
      recv_stall_pct = 0;
    end
  endtask

  // Random sample parts, mostly full range with extremes mixed in.
  function automatic logic [15:0] pick_part();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'(int'($urandom_range(7)) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_random(int count);
    repeat (count) send_sample(pick_part(), pick_part());
    in_valid <= 1'b0;
  endtask

  // Registers change only once the block has drained; the extra cycles cover
  // the last result leaving the output stage.
  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    while (sb.awaiting.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  task automatic set_all(logic [CFG_W-1:0] win, logic [CFG_W-1:0] lg, bit nrm, bit cj);
    write_reg(REG_WINDOW_LEN, win);
    write_reg(REG_LAG, lg);
    write_reg(REG_NORMALIZE, CFG_W'(nrm));
    write_reg(REG_CONJ, CFG_W'(cj));
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset settings: corner values of both parts.
    send_sample(16'h8000, 16'h8000);
    send_sample(16'h7FFF, 16'h7FFF);
    send_sample(16'h8000, 16'h7FFF);
    send_sample(16'h7FFF, 16'h8000);
    send_sample(16'h0000, 16'hFFFF);
    send_sample(16'h0001, 16'h0000);
    send_sample(16'hFFFF, 16'h0001);
    send_sample(16'h5555, 16'hAAAA);
    in_valid <= 1'b0;

    // Normalizing with window zero, which acts as one, and lag zero, which
    // correlates each sample with itself: a zero sample leaves both energies
    // at zero, which forces a zero result with energy_zero set.
    set_all(11'd0, 11'd0, 1'b1, 1'b1);
    send_sample(16'h8000, 16'h8000);
    send_sample(16'h0000, 16'h0000);
    send_sample(16'h7FFF, 16'h0001);
    send_random(50);

    // Oversized window and lag fall back to the largest supported values; the
    // run is long enough to wrap the delay line.
    set_all(11'h7FF, 11'h7FF, 1'b0, 1'b0);
    send_random(1350);

    set_all(11'd1, 11'd1, 1'b1, 1'b0);
    send_random(60);

    set_all(11'd16, 11'd64, 1'b1, 1'b1);
    send_random(150);

    set_all(11'd300, 11'd5, 1'b0, 1'b1);
    send_random(200);

    set_all(11'd256, 11'd1024, 1'b1, 1'b0);
    send_random(30);

    while (sb.awaiting.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
